// ===== hw/rtl/rcfd_pkg.sv =====
`timescale 1ns / 1ps

package rcfd_pkg;

    // Frame layout
    localparam int FRAME_LEN  = 21;
    localparam int STORE_LEN  = 20;   // bytes 0..19 kept, byte 20 is the closing byte
    localparam int CRC_SPAN   = 19;
    localparam logic [5:0] COUNT_MAX = 6'd63;
    localparam logic [7:0] HDR0 = 8'hA9;
    localparam logic [7:0] HDR1 = 8'h53;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    // Channel widths
    localparam int CH_W  = 11;
    localparam int OUT_W = 12;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_LEN = 3'd1;
    localparam logic [2:0] ST_BAD_HDR = 3'd2;
    localparam logic [2:0] ST_BAD_CRC = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Config register indexes
    localparam logic [1:0] CFG_CHANNEL_MIN    = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_MAX    = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_CENTER = 2'd2;
    localparam logic [1:0] CFG_DEAD_ZONE      = 2'd3;

    // Output bus width (139 bits of fields, padded to bytes)
    localparam int M_DATA_W = 144;

    // Classified frame passed from front to back
    typedef struct packed {
        logic [2:0]      status;
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch3;
        logic [CH_W-1:0] wheel;
        logic [5:0]      buttons;
        logic [15:0]     dx;
        logic [15:0]     dy;
        logic [15:0]     dz;
        logic [5:0]      mbtn;
        logic [15:0]     key;
    } t_frame_rec;

endpackage

// ===== hw/rtl/rcfd_front.sv =====
`timescale 1ns / 1ps

module rcfd_front
    import rcfd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic [CH_W-1:0] i_chan_min,
    input  logic [CH_W-1:0] i_chan_max,
    output logic            o_push,
    output t_frame_rec      o_rec
);

    // Reflected CRC16 over one byte, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [7:0]  r_bytes [0:STORE_LEN-1];
    logic [5:0]  r_count;
    logic [15:0] r_crc;
    logic [5:0]  n_count;
    logic [15:0] n_crc;

    logic [CH_W-1:0] w_ch [0:3];
    logic            w_len_ok;
    logic            w_hdr_ok;
    logic            w_crc_ok;
    logic            w_range_ok;
    logic [2:0]      w_status;

    // Byte store, written while the burst is still inside the frame
    always_ff @(posedge i_clk) begin
        if (i_fire && (r_count < 6'(STORE_LEN))) begin
            r_bytes[r_count[4:0]] <= i_byte;
        end
    end

    // Count and CRC update
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (i_fire) begin
            if (r_count < 6'(CRC_SPAN)) begin
                n_crc = crc_byte(r_crc, i_byte);
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 6'd1;
            end
            if (i_last) begin
                n_count = '0;
                n_crc   = CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // Channel unpacking (11-bit fields, LSB first)
    assign w_ch[0] = {r_bytes[3][2:0], r_bytes[2]};
    assign w_ch[1] = {r_bytes[4][5:0], r_bytes[3][7:3]};
    assign w_ch[2] = {r_bytes[6][0], r_bytes[5], r_bytes[4][7:6]};
    assign w_ch[3] = {r_bytes[7][3:0], r_bytes[6][7:1]};

    // Frame checks; a good frame closes on byte 20, so bytes 0..19 are stored
    assign w_len_ok = (r_count == 6'(FRAME_LEN - 1));
    assign w_hdr_ok = (r_bytes[0] == HDR0) && (r_bytes[1] == HDR1);
    assign w_crc_ok = ({i_byte, r_bytes[19]} == r_crc);

    always_comb begin
        w_range_ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if ((w_ch[k] < i_chan_min) || (w_ch[k] > i_chan_max)) begin
                w_range_ok = 1'b0;
            end
        end
    end

    always_comb begin
        priority if (!w_len_ok) begin
            w_status = ST_BAD_LEN;
        end else if (!w_hdr_ok) begin
            w_status = ST_BAD_HDR;
        end else if (!w_crc_ok) begin
            w_status = ST_BAD_CRC;
        end else if (!w_range_ok) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    // Record handed to the queue on the closing byte
    assign o_push = i_fire && i_last;

    always_comb begin
        o_rec.status  = w_status;
        o_rec.ch0     = w_ch[0];
        o_rec.ch1     = w_ch[1];
        o_rec.ch2     = w_ch[2];
        o_rec.ch3     = w_ch[3];
        o_rec.wheel   = {r_bytes[9][3:0], r_bytes[8][7:1]};
        o_rec.buttons = {r_bytes[9][4], r_bytes[8][0], r_bytes[7][7], r_bytes[7][6],
                         r_bytes[7][5:4]};
        o_rec.dx      = {r_bytes[11], r_bytes[10]};
        o_rec.dy      = {r_bytes[13], r_bytes[12]};
        o_rec.dz      = {r_bytes[15], r_bytes[14]};
        o_rec.mbtn    = r_bytes[16][5:0];
        o_rec.key     = {r_bytes[18], r_bytes[17]};
    end

endmodule

// ===== hw/rtl/rcfd_queue.sv =====
`timescale 1ns / 1ps

module rcfd_queue
    import rcfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_frame_rec o_rec
);

    // Two-entry circular buffer
    t_frame_rec r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;

    assign o_full  = (r_level == 2'd2);
    assign o_empty = (r_level == 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ===== hw/rtl/rcfd_back.sv =====
`timescale 1ns / 1ps

module rcfd_back
    import rcfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_frame_rec          i_rec,
    output logic                o_pop,
    input  logic [CH_W-1:0]     i_center,
    input  logic [CH_W-1:0]     i_dead,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [M_DATA_W-1:0] o_data
);

    // Centered value, optional dead zone
    function automatic logic [OUT_W-1:0] center_val(input logic [CH_W-1:0] raw,
                                                   input logic [CH_W-1:0] ctr,
                                                   input logic [CH_W-1:0] dz,
                                                   input logic use_dead);
        logic [OUT_W-1:0] v;
        logic [OUT_W-1:0] mag;
        v   = {1'b0, raw} - {1'b0, ctr};
        mag = v[OUT_W-1] ? (~v + 12'd1) : v;
        if (use_dead && (mag <= {1'b0, dz})) begin
            v = '0;
        end
        return v;
    endfunction

    logic                r_valid;
    logic [M_DATA_W-1:0] r_data;
    logic [M_DATA_W-1:0] n_data;
    logic                w_ok;

    // Take the next record when the output register is free or draining
    assign o_pop = !i_empty && (!r_valid || i_ready);
    assign w_ok  = (i_rec.status == ST_OK);

    always_comb begin
        n_data = '0;
        n_data[2:0] = i_rec.status;
        if (w_ok) begin
            n_data[14:3]    = center_val(i_rec.ch0, i_center, i_dead, 1'b1);
            n_data[26:15]   = center_val(i_rec.ch1, i_center, i_dead, 1'b1);
            n_data[38:27]   = center_val(i_rec.ch2, i_center, i_dead, 1'b1);
            n_data[50:39]   = center_val(i_rec.ch3, i_center, i_dead, 1'b1);
            n_data[62:51]   = center_val(i_rec.wheel, i_center, i_dead, 1'b0);
            n_data[68:63]   = i_rec.buttons;
            n_data[84:69]   = i_rec.dx;
            n_data[100:85]  = i_rec.dy;
            n_data[116:101] = i_rec.dz;
            n_data[122:117] = i_rec.mbtn;
            n_data[138:123] = i_rec.key;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/remote_control_frame_decoder.sv =====
// Result path: the record of the closing byte is written into the queue, and
// then moved into the output register when that register is free or draining.
// The front stores and CRCs one byte per cycle unless the record queue is full.
// A 2-entry record queue lets the front keep taking bytes while a result waits.
// Reset (synchronous, active low) clears the byte count, CRC, queue and output
// valid, and loads the default channel limits, center and dead zone.
`timescale 1ns / 1ps

module remote_control_frame_decoder
    import rcfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [7:0] rx_byte
    input  logic                i_s_tlast,   // burst_end
    // Result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [2:0] frame_status, [14:3] stick_one, [26:15] stick_two,
    // [38:27] stick_three, [50:39] stick_four, [62:51] wheel_value,
    // [68:63] button_bits, [84:69] mouse_dx, [100:85] mouse_dy,
    // [116:101] mouse_dz, [122:117] mouse_buttons, [138:123] key_mask,
    // [143:139] zero
    output logic [M_DATA_W-1:0] o_m_tdata,
    // Config write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CH_W-1:0]     i_cfg_data
);

    logic [CH_W-1:0] r_chan_min;
    logic [CH_W-1:0] r_chan_max;
    logic [CH_W-1:0] r_chan_center;
    logic [CH_W-1:0] r_dead_zone;

    logic       w_fire;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_frame_rec w_rec_in;
    t_frame_rec w_rec_out;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_min    <= 11'd364;
            r_chan_max    <= 11'd1684;
            r_chan_center <= 11'd1024;
            r_dead_zone   <= 11'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_MIN:    r_chan_min    <= i_cfg_data;
                CFG_CHANNEL_MAX:    r_chan_max    <= i_cfg_data;
                CFG_CHANNEL_CENTER: r_chan_center <= i_cfg_data;
                CFG_DEAD_ZONE:      r_dead_zone   <= i_cfg_data;
                default:            r_dead_zone   <= r_dead_zone;
            endcase
        end
    end

    // Input transfer; hold off only when no queue slot is left
    assign o_s_tready = !w_full;
    assign w_fire     = i_s_tvalid && o_s_tready;

    rcfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_chan_min (r_chan_min),
        .i_chan_max (r_chan_max),
        .o_push     (w_push),
        .o_rec      (w_rec_in)
    );

    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_rec   (w_rec_out)
    );

    rcfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_rec    (w_rec_out),
        .o_pop    (w_pop),
        .i_center (r_chan_center),
        .i_dead   (r_dead_zone),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata)
    );

endmodule

// ===== hw/rtl/rcfd_checker.sv =====
`timescale 1ns / 1ps

module rcfd_checker
    import rcfd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [7:0]          i_s_tdata,
    input logic                i_s_tlast,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                i_cfg_we,
    input logic [1:0]          i_cfg_index,
    input logic [CH_W-1:0]     i_cfg_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= ST_RANGE))
        else $error("undefined status code");

    // Failed frames carry zero fields and zero padding
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != ST_OK) |-> (o_m_tdata[143:3] == '0))
        else $error("failed frame with nonzero fields");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind remote_control_frame_decoder rcfd_checker u_rcfd_checker (.*);

// ===== tb/frame_decode_checker.sv =====
`timescale 1ns / 1ps

module frame_decode_checker
    import rcfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_s_tlast,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CH_W-1:0]     i_cfg_data,
    output int                  o_fail_cnt,
    output int                  o_checked_cnt,
    output int                  o_good_cnt
);

    // Mirror of the decoder state and settings
    logic [7:0]      burst_bytes [FRAME_LEN];
    logic [5:0]      byte_cnt;
    logic [15:0]     crc_acc;
    logic [CH_W-1:0] lim_lo, lim_hi, ctr, dz;

    // Decoded results still owed by the block, oldest first
    logic [M_DATA_W-1:0] decoded_q [$];
    logic [M_DATA_W-1:0] want_word;
    int fail_total, checked_total, good_total;

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // Stick or wheel minus center, as a 12-bit two's-complement value
    function automatic logic [OUT_W-1:0] centered(logic [CH_W-1:0] raw, bit use_dz);
        int v, mag;
        v   = int'(raw) - int'(ctr);
        mag = (v < 0) ? -v : v;
        if (use_dz && mag <= int'(dz)) v = 0;
        return v[OUT_W-1:0];
    endfunction

    // Result for the burst that just closed
    function automatic logic [M_DATA_W-1:0] decode_burst();
        logic [M_DATA_W-1:0] r;
        logic [CH_W-1:0]     ch [4];
        logic [CH_W-1:0]     whl;
        logic [15:0]         crc_rx;
        logic [2:0]          st;
        r      = '0;
        ch[0]  = {burst_bytes[3][2:0], burst_bytes[2]};
        ch[1]  = {burst_bytes[4][5:0], burst_bytes[3][7:3]};
        ch[2]  = {burst_bytes[6][0], burst_bytes[5], burst_bytes[4][7:6]};
        ch[3]  = {burst_bytes[7][3:0], burst_bytes[6][7:1]};
        whl    = {burst_bytes[9][3:0], burst_bytes[8][7:1]};
        crc_rx = {burst_bytes[20], burst_bytes[19]};

        if (byte_cnt != FRAME_LEN) begin
            st = ST_BAD_LEN;
        end else if (burst_bytes[0] != HDR0 || burst_bytes[1] != HDR1) begin
            st = ST_BAD_HDR;
        end else if (crc_rx != crc_acc) begin
            st = ST_BAD_CRC;
        end else begin
            st = ST_OK;
            for (int i = 0; i < 4; i++) begin
                if (ch[i] < lim_lo || ch[i] > lim_hi) st = ST_RANGE;
            end
        end

        r[2:0] = st;
        if (st == ST_OK) begin
            r[14:3]    = centered(ch[0], 1'b1);
            r[26:15]   = centered(ch[1], 1'b1);
            r[38:27]   = centered(ch[2], 1'b1);
            r[50:39]   = centered(ch[3], 1'b1);
            r[62:51]   = centered(whl, 1'b0);
            r[68:63]   = {burst_bytes[9][4], burst_bytes[8][0], burst_bytes[7][7:4]};
            r[84:69]   = {burst_bytes[11], burst_bytes[10]};
            r[100:85]  = {burst_bytes[13], burst_bytes[12]};
            r[116:101] = {burst_bytes[15], burst_bytes[14]};
            r[122:117] = burst_bytes[16][5:0];
            r[138:123] = {burst_bytes[18], burst_bytes[17]};
        end
        return r;
    endfunction

    // One line per mismatch, printing capped to keep the log short
    task automatic report(string what, logic [15:0] ev, logic [15:0] gv);
        if (fail_total < 40) begin
            $display("[%0t] %s: expected %h, got %h", $time, what, ev, gv);
        end
        fail_total++;
    endtask

    task automatic check_field(string what, logic [15:0] ev, logic [15:0] gv);
        if (ev !== gv) report(what, ev, gv);
    endtask

    task automatic compare_result(logic [M_DATA_W-1:0] e, logic [M_DATA_W-1:0] g);
        check_field("frame_status", 16'(e[2:0]), 16'(g[2:0]));
        check_field("stick_one", 16'(e[14:3]), 16'(g[14:3]));
        check_field("stick_two", 16'(e[26:15]), 16'(g[26:15]));
        check_field("stick_three", 16'(e[38:27]), 16'(g[38:27]));
        check_field("stick_four", 16'(e[50:39]), 16'(g[50:39]));
        check_field("wheel_value", 16'(e[62:51]), 16'(g[62:51]));
        check_field("button_bits", 16'(e[68:63]), 16'(g[68:63]));
        check_field("mouse_dx", e[84:69], g[84:69]);
        check_field("mouse_dy", e[100:85], g[100:85]);
        check_field("mouse_dz", e[116:101], g[116:101]);
        check_field("mouse_buttons", 16'(e[122:117]), 16'(g[122:117]));
        check_field("key_mask", e[138:123], g[138:123]);
        check_field("padding", 16'(e[143:139]), 16'(g[143:139]));
    endtask

    // Watch config writes, input transfers and result transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_cnt = '0;
            crc_acc  = CRC_INIT;
            lim_lo   = 11'd364;
            lim_hi   = 11'd1684;
            ctr      = 11'd1024;
            dz       = 11'd10;
            for (int i = 0; i < FRAME_LEN; i++) burst_bytes[i] = '0;
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CHANNEL_MIN:    lim_lo = i_cfg_data;
                    CFG_CHANNEL_MAX:    lim_hi = i_cfg_data;
                    CFG_CHANNEL_CENTER: ctr    = i_cfg_data;
                    CFG_DEAD_ZONE:      dz     = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                if (byte_cnt < FRAME_LEN) burst_bytes[byte_cnt] = i_s_tdata;
                if (byte_cnt < CRC_SPAN) crc_acc = crc16_step(crc_acc, i_s_tdata);
                if (byte_cnt != COUNT_MAX) byte_cnt++;
                if (i_s_tlast) begin
                    want_word = decode_burst();
                    if (want_word[2:0] == ST_OK) good_total++;
                    decoded_q.push_back(want_word);
                    byte_cnt = '0;
                    crc_acc  = CRC_INIT;
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    report("result with no burst pending", 16'h0, i_m_tdata[15:0]);
                end else begin
                    want_word = decoded_q.pop_front();
                    compare_result(want_word, i_m_tdata);
                    checked_total++;
                end
            end
        end
        o_fail_cnt    <= fail_total;
        o_checked_cnt <= checked_total;
        o_good_cnt    <= good_total;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rcfd_pkg::*;

    typedef enum int {
        BK_GOOD, BK_RANGE, BK_CRC, BK_HDR, BK_SHORT, BK_LONG, BK_RAW21
    } t_burst_kind;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;
    logic                i_s_tlast;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [CH_W-1:0]     i_cfg_data;

    int fail_cnt, checked_cnt, good_cnt;

    // Settings as last written, used to aim stick values
    logic [CH_W-1:0] set_min = 11'd364;
    logic [CH_W-1:0] set_max = 11'd1684;
    logic [CH_W-1:0] set_ctr = 11'd1024;
    logic [CH_W-1:0] set_dz  = 11'd10;

    logic [7:0]  burst_q [$];
    logic [11:0] stall_cycle = '0;
    int bytes_sent, bursts_sent, run_left, settings_used;

    remote_control_frame_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    frame_decode_checker decode_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_cnt    (fail_cnt),
        .o_checked_cnt (checked_cnt),
        .o_good_cnt    (good_cnt)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: free flow, light random stalls, long fixed stalls, heavy stalls
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 12'd1;
        case (stall_cycle[10:9])
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= ($urandom_range(3) != 0);
            2'd2: i_m_tready <= (stall_cycle[4:0] >= 5'd20);
            default: i_m_tready <= ($urandom_range(9) < 3);
        endcase
    end

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // Stick value inside the window: edges, around the dead zone, or anywhere
    function automatic logic [CH_W-1:0] pick_stick();
        int v;
        case ($urandom_range(5))
            0: v = set_min;
            1: v = set_max;
            2, 3: v = int'(set_ctr) - int'(set_dz) - 2 + int'($urandom_range(2 * set_dz + 4));
            default: v = $urandom_range(set_max, set_min);
        endcase
        if (set_min <= set_max) begin
            if (v < int'(set_min)) v = set_min;
            if (v > int'(set_max)) v = set_max;
        end
        if (v < 0) v = 0;
        if (v > 2047) v = 2047;
        return v[CH_W-1:0];
    endfunction

    // Stick value outside the window, where one exists
    function automatic logic [CH_W-1:0] pick_outside();
        if (set_min > 0 && (set_max == 11'h7FF || $urandom_range(1) == 0)) begin
            return 11'($urandom_range(int'(set_min) - 1, 0));
        end
        if (set_max < 11'h7FF) return 11'($urandom_range(2047, int'(set_max) + 1));
        return 11'($urandom);
    endfunction

    function automatic t_burst_kind pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 55) return BK_GOOD;
        if (p < 65) return BK_RANGE;
        if (p < 73) return BK_CRC;
        if (p < 80) return BK_HDR;
        if (p < 88) return BK_SHORT;
        if (p < 94) return BK_LONG;
        return BK_RAW21;
    endfunction

    // Well-formed frame with the given channels; fill: 0 random, 1 zeros, 2 ones
    task automatic build_good(input logic [CH_W-1:0] c0, c1, c2, c3, whl, input int fill);
        logic [167:0] fb;
        logic [15:0]  crc;
        for (int i = 0; i < FRAME_LEN; i++) begin
            fb[i*8 +: 8] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
        end
        fb[15:0]  = {HDR1, HDR0};
        fb[26:16] = c0;
        fb[37:27] = c1;
        fb[48:38] = c2;
        fb[59:49] = c3;
        fb[75:65] = whl;
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) crc = crc16_step(crc, fb[i*8 +: 8]);
        fb[167:152] = crc;
        burst_q.delete();
        for (int i = 0; i < FRAME_LEN; i++) burst_q.push_back(fb[i*8 +: 8]);
    endtask

    task automatic build_random(input int len);
        burst_q.delete();
        for (int i = 0; i < len; i++) burst_q.push_back(8'($urandom));
    endtask

    task automatic build_random_good();
        int fill;
        fill = $urandom_range(19);
        if (fill > 2) fill = 0;
        build_good(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                   11'($urandom), fill);
    endtask

    // One random burst of the chosen kind
    task automatic build_burst(input t_burst_kind kind);
        logic [CH_W-1:0] ch [4];
        case (kind)
            BK_GOOD: build_random_good();
            BK_RANGE: begin
                for (int i = 0; i < 4; i++) ch[i] = pick_stick();
                ch[$urandom_range(3)] = pick_outside();
                build_good(ch[0], ch[1], ch[2], ch[3], 11'($urandom), 0);
            end
            BK_CRC: begin
                build_random_good();
                burst_q[$urandom_range(20, 2)] ^= 8'(1 << $urandom_range(7));
            end
            BK_HDR: begin
                build_random_good();
                burst_q[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
            end
            BK_SHORT: build_random($urandom_range(20, 1));
            BK_LONG: build_random($urandom_range(70, 22));
            default: begin
                build_random(FRAME_LEN);
                if ($urandom_range(1) == 0) begin
                    burst_q[0] = HDR0;
                    burst_q[1] = HDR1;
                end
            end
        endcase
    endtask

    // Sender: runs of random length with random gaps between them
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (run_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
            run_left = ($urandom_range(3) == 0) ? $urandom_range(150, 40) : $urandom_range(6, 1);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        run_left--;
        bytes_sent++;
    endtask

    task automatic send_burst();
        for (int i = 0; i < burst_q.size(); i++) push_byte(burst_q[i], i == burst_q.size() - 1);
        bursts_sent++;
    endtask

    // Drain: every burst answered, then let the pipeline settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (checked_cnt < bursts_sent) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CH_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CH_W-1:0] lo, hi, c, z);
        write_reg(CFG_CHANNEL_MIN, lo);
        write_reg(CFG_CHANNEL_MAX, hi);
        write_reg(CFG_CHANNEL_CENTER, c);
        write_reg(CFG_DEAD_ZONE, z);
        i_cfg_we <= 1'b0;
        set_min = lo;
        set_max = hi;
        set_ctr = c;
        set_dz  = z;
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_burst(pick_kind());
            send_burst();
        end
        wait_idle();
    endtask

    // Run limit
    initial begin
        #3_000_000;
        $display("** remote_control_frame_decoder: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_CHANNEL_MIN;
        i_cfg_data  = '0;
        settings_used = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bursts under reset settings
        build_good(set_min, set_max, set_min, set_max, 11'd0, 1);
        send_burst();
        build_good(set_max, set_min, set_max, set_min, 11'h7FF, 2);
        send_burst();
        // dead zone edges: at, just inside, just outside
        build_good(set_ctr, set_ctr + set_dz, set_ctr - set_dz, set_ctr + set_dz + 11'd1,
                   set_ctr, 0);
        send_burst();
        build_good(set_ctr - set_dz - 11'd1, set_ctr + 11'd1, set_ctr - 11'd1, set_ctr,
                   set_ctr - 11'd1, 0);
        send_burst();
        // bad header, in either byte; header check wins over a bad crc
        build_random_good();
        burst_q[0] ^= 8'h01;
        send_burst();
        build_random_good();
        burst_q[1] ^= 8'h80;
        burst_q[19] ^= 8'h01;
        send_burst();
        // bad crc in the low and the high byte
        build_random_good();
        burst_q[19] ^= 8'h01;
        send_burst();
        build_random_good();
        burst_q[20] ^= 8'h80;
        send_burst();
        // one stick just below the minimum, one just above the maximum
        build_good(set_min - 11'd1, set_ctr, set_ctr, set_ctr, set_ctr, 0);
        send_burst();
        build_good(set_ctr, set_ctr, set_ctr, set_max + 11'd1, set_ctr, 0);
        send_burst();
        // length errors: one byte, good frame cut short or extended, saturating run
        build_random(1);
        burst_q[0] = 8'hFF;
        send_burst();
        build_random_good();
        void'(burst_q.pop_back());
        send_burst();
        build_random_good();
        burst_q.push_back(8'($urandom));
        send_burst();
        build_random(70);
        send_burst();
        build_random_good();
        send_burst();
        wait_idle();
        run_phase(180);

        // Setting sweeps, extremes first
        apply_settings(11'd0, 11'h7FF, 11'd0, 11'd0);
        run_phase(220);
        apply_settings(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
        run_phase(200);
        apply_settings(11'd1500, 11'd400, 11'd1024, 11'd5);
        run_phase(160);
        apply_settings(11'd0, 11'd0, 11'd0, 11'h7FF);
        run_phase(180);
        for (int p = 0; p < 2; p++) begin
            apply_settings(11'($urandom_range(1000)), 11'($urandom_range(2047, 1000)),
                           11'($urandom_range(2047)), 11'($urandom_range(100)));
            run_phase(250);
        end

        $display("Sent %0d bytes in %0d bursts under %0d register settings.",
                 bytes_sent, bursts_sent, settings_used);
        $display("Checked %0d decoded results, %0d of them good frames.",
                 checked_cnt, good_cnt);
        if (fail_cnt == 0) begin
            $display("** remote_control_frame_decoder: PASSED **");
        end else begin
            $display("** remote_control_frame_decoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rcfd_pkg.sv
hw/rtl/rcfd_front.sv
hw/rtl/rcfd_queue.sv
hw/rtl/rcfd_back.sv
hw/rtl/remote_control_frame_decoder.sv
hw/rtl/rcfd_checker.sv
tb/frame_decode_checker.sv
tb/testbench.sv
